// ===== rtl/rfpd_pkg.sv =====
package rfpd_pkg;

  localparam int PULSE_W = 16;
  localparam int ID_W = 24;
  localparam int LOW_W = 16;
  localparam int CNT_W = 6;
  localparam int CFG_IDX_W = 3;

  // Pulses per packet, 4 to 62
  localparam int PULSE_COUNT = 50;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W:0] PULSE_COUNT_X = (CNT_W + 1)'(PULSE_COUNT);

  localparam logic [ID_W-1:0] ID_ONES = '1;
  localparam logic [LOW_W-1:0] LOW_ONES = '1;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAP_MAX        = 3'd0,
    REG_SHORT_MIN      = 3'd1,
    REG_SHORT_MAX      = 3'd2,
    REG_LONG_THRESHOLD = 3'd3,
    REG_LONG_MAX       = 3'd4
  } cfg_reg_e;

  localparam logic [PULSE_W-1:0] GAP_MAX_RST        = 16'd1000;
  localparam logic [PULSE_W-1:0] SHORT_MIN_RST      = 16'd1000;
  localparam logic [PULSE_W-1:0] SHORT_MAX_RST      = 16'd1500;
  localparam logic [PULSE_W-1:0] LONG_THRESHOLD_RST = 16'd2000;
  localparam logic [PULSE_W-1:0] LONG_MAX_RST       = 16'd2800;

  // One classified pulse
  typedef struct packed {
    logic data;      // shifts a bit into the ID
    logic data_bit;
    logic err;
    logic last;
    logic len_ok;    // packet length matches PULSE_COUNT so far
  } tok_t;

endpackage

// ===== rtl/rfpd_pulse_if.sv =====
interface rfpd_pulse_if import rfpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_length;
  logic               last_pulse;

  modport source(output valid, pulse_length, last_pulse, input ready);
  modport sink(input valid, pulse_length, last_pulse, output ready);
endinterface

// ===== rtl/rfpd_frame_if.sv =====
interface rfpd_frame_if import rfpd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] device_id;
  logic            frame_valid;

  modport source(output valid, device_id, frame_valid, input ready);
  modport sink(input valid, device_id, frame_valid, output ready);
endinterface

// ===== rtl/rfpd_cfg_if.sv =====
interface rfpd_cfg_if import rfpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PULSE_W-1:0]   data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/rfpd_front.sv =====
module rfpd_front import rfpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  rfpd_pulse_if.sink   pulse_in,
  rfpd_cfg_if.sink     cfg,
  input  logic         q_full,
  output logic         push,
  output tok_t         tok
);

  logic [PULSE_W-1:0] gap_max;
  logic [PULSE_W-1:0] short_min;
  logic [PULSE_W-1:0] short_max;
  logic [PULSE_W-1:0] long_threshold;
  logic [PULSE_W-1:0] long_max;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [CNT_W:0]   n_x;
  logic [PULSE_W-1:0] p;
  logic             is_one;

  assign cfg.ready = 1'b1;
  assign pulse_in.ready = !q_full;
  assign push = pulse_in.valid && !q_full;
  assign p = pulse_in.pulse_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_max        <= GAP_MAX_RST;
      short_min      <= SHORT_MIN_RST;
      short_max      <= SHORT_MAX_RST;
      long_threshold <= LONG_THRESHOLD_RST;
      long_max       <= LONG_MAX_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_GAP_MAX:        gap_max <= cfg.data;
        REG_SHORT_MIN:      short_min <= cfg.data;
        REG_SHORT_MAX:      short_max <= cfg.data;
        REG_LONG_THRESHOLD: long_threshold <= cfg.data;
        REG_LONG_MAX:       long_max <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_next = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
    n_x = {1'b0, cnt_next};
    is_one = p > long_threshold;
    tok = '0;
    tok.last = pulse_in.last_pulse;
    tok.len_ok = n_x == PULSE_COUNT_X;
    if (!cnt_next[0]) begin
      tok.data = n_x < PULSE_COUNT_X;
      tok.data_bit = is_one;
      tok.err = tok.data && (is_one ? (p > long_max) : (p > short_max || p < short_min));
    end else begin
      tok.err = (n_x + 1'b1 < PULSE_COUNT_X) && (p > gap_max);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push) begin
      cnt <= pulse_in.last_pulse ? '0 : cnt_next;
    end
  end

endmodule

// ===== rtl/rfpd_queue.sv =====
module rfpd_queue import rfpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  output logic q_valid,
  output tok_t q_tok,
  input  logic pop
);

  tok_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full = count == Q_CNT_W'(Q_DEPTH);
  assign q_valid = count != '0;
  assign q_tok = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rfpd_back.sv =====
module rfpd_back import rfpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  tok_t         q_tok,
  output logic         pop,
  rfpd_frame_if.source frame_out
);

  logic [ID_W-1:0] bit_shift;
  logic [ID_W-1:0] bit_shift_next;
  logic            pulse_error;
  logic            pulse_error_next;
  logic            id_ok;

  logic            out_valid;
  logic [ID_W-1:0] out_id;
  logic            out_ok;

  assign pop = q_valid && (!q_tok.last || !out_valid || frame_out.ready);

  always_comb begin
    bit_shift_next = q_tok.data ? {bit_shift[ID_W-2:0], q_tok.data_bit} : bit_shift;
    pulse_error_next = pulse_error || q_tok.err;
    id_ok = q_tok.len_ok && !pulse_error_next && (bit_shift_next != '0) &&
            (bit_shift_next != ID_ONES) && (bit_shift_next[LOW_W-1:0] != LOW_ONES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_shift   <= '0;
      pulse_error <= 1'b0;
    end else if (pop) begin
      if (q_tok.last) begin
        bit_shift   <= '0;
        pulse_error <= 1'b0;
      end else begin
        bit_shift   <= bit_shift_next;
        pulse_error <= pulse_error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_tok.last) begin
      out_valid <= 1'b1;
    end else if (frame_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_tok.last) begin
      out_id <= id_ok ? bit_shift_next : '0;
      out_ok <= id_ok;
    end
  end

  assign frame_out.valid = out_valid;
  assign frame_out.device_id = out_id;
  assign frame_out.frame_valid = out_ok;

endmodule

// ===== rtl/rf_pulse_width_frame_decoder_core.sv =====
// Pulse-width frame decoder: one pulse duration per transaction on pulse_in, the last pulse
// of a packet flagged by last_pulse, and one frame transaction on frame_out per packet with
// the 24-bit ID and its accept flag. Pulses are accepted one per cycle, back to back, while
// the queue is not full; each is classified against the threshold registers as it is
// accepted and passes through a 4-entry queue to the bit shifter. While frame_out is stalled
// the shifter keeps taking pulses until the next packet's last pulse reaches the queue head;
// the queue then fills and pulse_in.ready drops. The frame register loads at the edge that
// pops the last pulse, so the last pulse passes through the queue and the frame register
// before frame_out.valid rises. Threshold registers are written on cfg (always ready), take
// effect for pulses accepted after the write, and should be changed only between packets.
module rf_pulse_width_frame_decoder_core import rfpd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  rfpd_pulse_if.sink    pulse_in,
  rfpd_frame_if.source  frame_out,
  rfpd_cfg_if.sink      cfg
);

  logic q_full;
  logic push;
  tok_t push_tok;
  logic q_valid;
  tok_t q_tok;
  logic pop;

  rfpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pulse_in (pulse_in),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .tok      (push_tok)
  );

  rfpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_tok    (q_tok),
    .pop      (pop)
  );

  rfpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_tok     (q_tok),
    .pop       (pop),
    .frame_out (frame_out)
  );

`ifndef SYNTH
  a_accepted_id_legal: assert property (@(posedge clk) disable iff (rst)
    frame_out.valid && frame_out.frame_valid |->
      frame_out.device_id != '0 && frame_out.device_id != ID_ONES &&
      frame_out.device_id[LOW_W-1:0] != LOW_ONES)
    else $error("accepted frame carries an illegal ID");

  a_rejected_id_zero: assert property (@(posedge clk) disable iff (rst)
    frame_out.valid && !frame_out.frame_valid |-> frame_out.device_id == '0)
    else $error("rejected frame carries a nonzero ID");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !pulse_in.ready && !push)
    else $error("pulse taken while queue full");
`endif

endmodule
